@@ rtl/valve_position_mode_machine_assert.svh @@
// ----------------------------------------------------------------------------
// valve position mode machine assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef VALVE_POSITION_MODE_MACHINE_ASSERT_SVH
`define VALVE_POSITION_MODE_MACHINE_ASSERT_SVH

// same-cycle implication
`define VPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vpm check failed");

// next-cycle implication
`define VPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vpm check failed");

`endif

@@ rtl/vpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_pkg
// shared types and constants of the valve position mode machine
// ----------------------------------------------------------------------------
package vpm_pkg;

  localparam int DbWidth  = 10;
  localparam int StWidth  = 10;
  localparam int FsWidth  = 14;
  localparam int CfgWidth = 14;
  localparam int IdxWidth = 2;
  localparam int TgtWidth = 14;
  localparam int OutPosWidth = 16;

  localparam logic [DbWidth-1:0] DeadbandRst  = 10'd10;
  localparam logic [StWidth-1:0] StepSizeRst  = 10'd10;
  localparam logic [FsWidth-1:0] FullScaleRst = 14'd1000;

  typedef enum logic [IdxWidth-1:0] {
    REG_DEADBAND   = 2'd0,
    REG_STEP_SIZE  = 2'd1,
    REG_FULL_SCALE = 2'd2
  } vpm_reg_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_OPEN   = 3'd1,
    MODE_CLOSED = 3'd2,
    MODE_UP     = 3'd3,
    MODE_DOWN   = 3'd4
  } vpm_mode_e;

  typedef struct packed {
    logic [DbWidth-1:0] deadband;
    logic [StWidth-1:0] step_size;
    logic [FsWidth-1:0] full_scale;
  } vpm_cfg_t;

endpackage

@@ rtl/valve_position_mode_machine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_position_mode_machine
// simulated valve actuator with idle, open, closed, up and down modes
// ----------------------------------------------------------------------------
// Each accepted item (tuser 0 = new set position in tdata, tuser 1 = timer
// tick) yields exactly one result of position, mode and moving flag. The
// block takes one item every clock cycle while the result side does not stall;
// a result is presented on the master side through an input register and a
// result register, and the valve state is updated as the result register
// loads. Back-pressure on the result side holds the input register, so up to
// two items can be held while the output stalls. Configuration writes take
// effect on the next cycle and are meant for idle periods.
module valve_position_mode_machine
  import vpm_pkg::*;
#(
  parameter int POS_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // target_position[13:0], zero pad
  input  logic                s_axis_tuser,  // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata   // position[15:0], mode[18:16], moving[19]
);

  vpm_cfg_t cfg;

  logic                in_valid_q;
  logic                in_cmd_q;
  logic [TgtWidth-1:0] in_tgt_q;
  logic                out_valid_q;
  logic [23:0]         out_data_q;
  logic [23:0]         out_data_d;
  logic                advance;

  logic signed [POS_WIDTH-1:0] cur_q, goal_q, step_q;
  logic signed [POS_WIDTH-1:0] cur_d, goal_d, step_d;
  vpm_mode_e                   mode_q, mode_d;

  vpm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vpm_step #(
    .POS_WIDTH (POS_WIDTH)
  ) u_step (
    .cfg_i    (cfg),
    .cmd_i    (in_cmd_q),
    .target_i (in_tgt_q),
    .cur_i    (cur_q),
    .goal_i   (goal_q),
    .step_i   (step_q),
    .mode_i   (mode_q),
    .cur_o    (cur_d),
    .goal_o   (goal_d),
    .step_o   (step_d),
    .mode_o   (mode_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign out_data_d = {4'b0000,
                       (mode_d == MODE_UP || mode_d == MODE_DOWN),
                       mode_d,
                       OutPosWidth'($signed(cur_d))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      goal_q      <= '0;
      step_q      <= '0;
      mode_q      <= MODE_IDLE;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cur_q       <= cur_d;
        goal_q      <= goal_d;
        step_q      <= step_d;
        mode_q      <= mode_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= s_axis_tuser;
      in_tgt_q <= s_axis_tdata[TgtWidth-1:0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/vpm_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_cfg
// configuration register file: deadband, step size, full scale
// ----------------------------------------------------------------------------
module vpm_cfg
  import vpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output vpm_cfg_t            cfg_o
);

  vpm_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband   <= DeadbandRst;
      cfg_q.step_size  <= StepSizeRst;
      cfg_q.full_scale <= FullScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEADBAND:   cfg_q.deadband   <= cfg_data_i[DbWidth-1:0];
        REG_STEP_SIZE:  cfg_q.step_size  <= cfg_data_i[StWidth-1:0];
        REG_FULL_SCALE: cfg_q.full_scale <= cfg_data_i[FsWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/vpm_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_step
// next-state logic for one set-position or tick item
// ----------------------------------------------------------------------------
module vpm_step
  import vpm_pkg::*;
#(
  parameter int POS_WIDTH = 16
) (
  input  vpm_cfg_t                     cfg_i,
  input  logic                         cmd_i,
  input  logic [TgtWidth-1:0]          target_i,
  input  logic signed [POS_WIDTH-1:0]  cur_i,
  input  logic signed [POS_WIDTH-1:0]  goal_i,
  input  logic signed [POS_WIDTH-1:0]  step_i,
  input  vpm_mode_e                    mode_i,
  output logic signed [POS_WIDTH-1:0]  cur_o,
  output logic signed [POS_WIDTH-1:0]  goal_o,
  output logic signed [POS_WIDTH-1:0]  step_o,
  output vpm_mode_e                    mode_o
);

  localparam int EW = POS_WIDTH + 2;
  localparam int CW = ((POS_WIDTH > 15) ? POS_WIDTH : 15) + 1;

  logic signed [POS_WIDTH-1:0] tgt_w;
  logic signed [POS_WIDTH-1:0] step_up;
  logic signed [POS_WIDTH-1:0] step_dn;
  logic signed [EW-1:0]        err;
  logic signed [EW-1:0]        db_s;
  logic signed [POS_WIDTH-1:0] p_nxt;
  logic signed [CW-1:0]        p_c;
  logic signed [CW-1:0]        fs_c;
  logic signed [CW-1:0]        st_c;
  logic                        err_gt_db;
  logic                        err_lt_ndb;

  assign tgt_w   = POS_WIDTH'(target_i);
  assign step_up = POS_WIDTH'(cfg_i.step_size);
  assign step_dn = -step_up;
  assign err     = EW'($signed(tgt_w)) - EW'($signed(cur_i));
  assign db_s    = EW'($signed({1'b0, cfg_i.deadband}));
  assign err_gt_db  = err > db_s;
  assign err_lt_ndb = err < -db_s;

  assign p_nxt = cur_i + step_i;
  assign p_c   = CW'($signed(p_nxt));
  assign fs_c  = CW'($signed({1'b0, cfg_i.full_scale}));
  assign st_c  = CW'($signed({1'b0, cfg_i.step_size}));

  always_comb begin
    cur_o  = cur_i;
    goal_o = goal_i;
    step_o = step_i;
    mode_o = mode_i;
    if (!cmd_i) begin
      goal_o = tgt_w;
      unique case (mode_i)
        MODE_IDLE: begin
          if (err_gt_db) begin
            step_o = step_up;
            mode_o = MODE_UP;
          end else if (err_lt_ndb) begin
            step_o = step_dn;
            mode_o = MODE_DOWN;
          end
        end
        MODE_OPEN: begin
          if (err_lt_ndb) begin
            step_o = step_dn;
            mode_o = MODE_DOWN;
          end
        end
        MODE_CLOSED: begin
          if (err_gt_db) begin
            step_o = step_up;
            mode_o = MODE_UP;
          end
        end
        MODE_UP: begin
          if (err < 0) begin
            step_o = '0;
            mode_o = MODE_IDLE;
          end
        end
        MODE_DOWN: begin
          if (err > 0) begin
            step_o = '0;
            mode_o = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end else if (mode_i == MODE_UP || mode_i == MODE_DOWN) begin
      cur_o = p_nxt;
      if (p_nxt == goal_i) begin
        if (p_c >= fs_c - st_c) begin
          mode_o = MODE_OPEN;
        end else if (p_c < st_c) begin
          mode_o = MODE_CLOSED;
        end else begin
          mode_o = MODE_IDLE;
        end
      end else if (p_nxt >= goal_i && mode_i == MODE_UP) begin
        mode_o = MODE_IDLE;
      end else if (p_nxt <= goal_i && mode_i == MODE_DOWN) begin
        mode_o = MODE_IDLE;
      end else if (p_c >= fs_c) begin
        mode_o = MODE_OPEN;
      end else if (p_c <= 0) begin
        mode_o = MODE_CLOSED;
      end
    end
  end

endmodule

@@ rtl/vpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpm_checker
// port-level checks of the valve position mode machine
// ----------------------------------------------------------------------------
`include "valve_position_mode_machine_assert.svh"

module vpm_checker
  import vpm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [23:0]         m_axis_tdata
);

  logic        out_xfer;
  logic        seen_q;
  logic        last_moving_q;
  logic [15:0] last_pos_q;
  logic [2:0]  out_mode;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_mode = m_axis_tdata[18:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_moving_q <= 1'b0;
      last_pos_q    <= '0;
    end else if (out_xfer) begin
      seen_q        <= 1'b1;
      last_moving_q <= m_axis_tdata[19];
      last_pos_q    <= m_axis_tdata[15:0];
    end
  end

  // moving flag agrees with the mode field
  `VPM_ASSERT_NOW(a_moving_flag, m_axis_tvalid,
    m_axis_tdata[19] == (out_mode == MODE_UP || out_mode == MODE_DOWN))

  // position only changes after a result that was moving
  `VPM_ASSERT_NOW(a_pos_hold, out_xfer && seen_q && !last_moving_q,
    m_axis_tdata[15:0] == last_pos_q)

  // stalled result holds
  `VPM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind valve_position_mode_machine vpm_checker u_vpm_checker (.*);
